[hw/rtl/f32gemm_pkg.sv]
// Package with the state codes, register indexes and IEEE single constants of the GEMM row engine.
`default_nettype none
package f32gemm_pkg;

	// Result items per row never exceed this count.
	localparam int RESULT_CAP = 16;

	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
	localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [31:0] INF_BITS    = 32'h7F80_0000;

	// Input transaction commands.
	localparam logic CMD_B = 1'b0;
	localparam logic CMD_A = 1'b1;

	// Configuration register indexes (byte address / 4).
	typedef enum logic [1:0] {
		REG_K_COUNT   = 2'd0,
		REG_N_COUNT   = 2'd1,
		REG_ROW_COUNT = 2'd2
	} reg_idx_t;

	// Sequencer states, one-hot.
	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_RD   = 12'b0000_0000_0010,
		S_UNPK = 12'b0000_0000_0100,
		S_NRMP = 12'b0000_0000_1000,
		S_NRMC = 12'b0000_0001_0000,
		S_ALGN = 12'b0000_0010_0000,
		S_ADD  = 12'b0000_0100_0000,
		S_NRMR = 12'b0000_1000_0000,
		S_RND1 = 12'b0001_0000_0000,
		S_RND2 = 12'b0010_0000_0000,
		S_WB   = 12'b0100_0000_0000,
		S_OUT  = 12'b1000_0000_0000
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/f32_gemm_row_engine.sv]
// Top level of the single precision GEMM row engine with its shared FMA datapath.
`default_nettype none
// The engine keeps a K by N matrix B in an internal memory and computes one row of
// C = A x B at a time. A cmd 0 transaction stores one B element; a cmd 1 transaction
// carries A[m][k] and is fused-multiply-added, rounded once to nearest even, into each
// of the N column sums by one shared FMA datapath stepped by a sequencer. Per column
// the sequencer goes through the B memory read, the unpack, the alignment, the addition,
// two rounding steps and the write back, with a shared normalizer that shifts by 16, 4
// or 1 bit per cycle on each of its three uses; when A or the B element is a zero, or
// an operand is an infinity or a NaN, only the read, the unpack and the write back
// are stepped. One A element thus occupies the block for all N columns, and the block
// is not ready meanwhile. The last k of a row then presents the N results one per cycle
// as the output side takes them. B entries that were never written read as arbitrary
// data. There is no clearing pass after reset.
module f32_gemm_row_engine #(
	parameter int MAX_K = 256,
	parameter int MAX_N = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Input channel.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [7:0]  k_index,
	input  wire logic [3:0]  col_index,
	input  wire logic [31:0] value,
	// Output channel.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] out_row,
	output logic      [3:0]  out_col,
	output logic      [31:0] out_value,
	output logic             row_last,
	output logic             matrix_last
);
	import f32gemm_pkg::*;

	localparam int BD   = MAX_K * MAX_N;
	localparam int AW   = (BD > 1) ? $clog2(BD) : 1;
	localparam int NCAP = (MAX_N < RESULT_CAP) ? MAX_N : RESULT_CAP;

	// Configuration registers.
	logic [8:0]  k_count_q;
	logic [4:0]  n_count_q;
	logic [15:0] row_count_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_count_q   <= 9'd1;
			n_count_q   <= 5'd1;
			row_count_q <= 16'd1;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_K_COUNT:   k_count_q   <= pwdata[8:0];
				REG_N_COUNT:   n_count_q   <= pwdata[4:0];
				REG_ROW_COUNT: row_count_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_K_COUNT:   prdata = {23'd0, k_count_q};
			REG_N_COUNT:   prdata = {27'd0, n_count_q};
			REG_ROW_COUNT: prdata = {16'd0, row_count_q};
			default:       prdata = 32'd0;
		endcase
	end

	// Effective dimensions after saturation.
	logic [9:0]  keff;
	logic [4:0]  neff;
	logic [15:0] rows_eff;
	always_comb begin
		if (k_count_q == 9'd0)
			keff = 10'd1;
		else if (32'(k_count_q) > MAX_K)
			keff = 10'(MAX_K);
		else
			keff = {1'b0, k_count_q};
		if (n_count_q == 5'd0)
			neff = 5'd1;
		else if (32'(n_count_q) > NCAP)
			neff = 5'(NCAP);
		else
			neff = n_count_q;
		rows_eff = (row_count_q == 16'd0) ? 16'd1 : row_count_q;
	end

	// Sequencer and datapath registers.
	state_t             state_q;
	logic [7:0]         k_q;
	logic [31:0]        a_q;
	logic [3:0]         col_q;
	logic [15:0]        row_q;
	logic [31:0]        sums_q [RESULT_CAP];
	logic [31:0]        bmem [BD];
	logic [31:0]        b_rd_q;
	logic [63:0]        nm_q;
	logic signed [11:0] ne_q;
	logic [63:0]        pm_q;
	logic signed [11:0] pe_q;
	logic [63:0]        mc_q;
	logic signed [11:0] xc_q;
	logic               sp_q;
	logic               sc_q;
	logic               czero_q;
	logic               rsign_q;
	logic [31:0]        res_q;
	logic [24:0]        q_q;
	logic               g_q;
	logic               st_q;
	logic               normal_q;
	logic               uzero_q;
	logic [8:0]         expf_q;

	logic in_acc, out_acc;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (state_q == S_OUT);
	assign out_acc   = out_valid && out_ready;

	// B memory: written on a cmd 0 transaction whose indexes are in range, read one column at a time.
	logic          b_wr_ok;
	logic [AW-1:0] b_wr_addr;
	logic [AW-1:0] b_rd_addr;
	assign b_wr_ok   = (32'(k_index) < MAX_K) && (32'(col_index) < MAX_N);
	assign b_wr_addr = AW'(32'(k_index) * MAX_N + 32'(col_index));
	assign b_rd_addr = AW'(32'(k_q) * MAX_N + 32'(col_q));

	always_ff @(posedge clk) begin
		if (in_acc && (cmd == CMD_B) && b_wr_ok)
			bmem[b_wr_addr] <= value;
		if (state_q == S_RD)
			b_rd_q <= bmem[b_rd_addr];
	end

	// Operand unpacking and special cases.
	logic [31:0] c_op;
	logic [7:0]  ea, eb, ec;
	logic        a_nan, b_nan, c_nan, a_zero, b_zero, c_zero, sp_w;
	logic        spec;
	logic [31:0] spec_val;
	logic [23:0] ma, mb, mcw;
	logic [47:0] prod;
	logic signed [11:0] pe_w, xc_w;
	always_comb begin
		c_op   = (k_q == 8'd0) ? 32'd0 : sums_q[col_q];
		ea     = a_q[30:23];
		eb     = b_rd_q[30:23];
		ec     = c_op[30:23];
		a_nan  = (ea == 8'hFF) && (a_q[22:0] != 23'd0);
		b_nan  = (eb == 8'hFF) && (b_rd_q[22:0] != 23'd0);
		c_nan  = (ec == 8'hFF) && (c_op[22:0] != 23'd0);
		a_zero = (a_q[30:0] == 31'd0);
		b_zero = (b_rd_q[30:0] == 31'd0);
		c_zero = (c_op[30:0] == 31'd0);
		sp_w   = a_q[31] ^ b_rd_q[31];
		spec     = 1'b1;
		spec_val = 32'd0;
		if (a_nan)
			spec_val = a_q | QUIET_BIT;
		else if (b_nan)
			spec_val = b_rd_q | QUIET_BIT;
		else if (c_nan)
			spec_val = c_op | QUIET_BIT;
		else if (ea == 8'hFF || eb == 8'hFF) begin
			if (a_zero || b_zero)
				spec_val = DEFAULT_NAN;
			else if (ec == 8'hFF && c_op[31] != sp_w)
				spec_val = DEFAULT_NAN;
			else
				spec_val = {sp_w, 31'd0} | INF_BITS;
		end else if (ec == 8'hFF)
			spec_val = c_op;
		else if (a_zero || b_zero)
			spec_val = c_zero ? {sp_w & c_op[31], 31'd0} : c_op;
		else
			spec = 1'b0;
		ma   = {(ea != 8'd0), a_q[22:0]};
		mb   = {(eb != 8'd0), b_rd_q[22:0]};
		mcw  = {(ec != 8'd0), c_op[22:0]};
		prod = ma * mb;
		pe_w = $signed({4'd0, (ea != 8'd0) ? ea : 8'd1})
		     + $signed({4'd0, (eb != 8'd0) ? eb : 8'd1}) - 12'sd300;
		xc_w = $signed({4'd0, (ec != 8'd0) ? ec : 8'd1}) - 12'sd150;
	end

	// Shared normalizer step: bring the leading one to bit 62.
	logic [63:0]        nm_nx;
	logic signed [11:0] ne_nx;
	logic               nrm_done;
	always_comb begin
		nrm_done = nm_q[62];
		nm_nx    = nm_q;
		ne_nx    = ne_q;
		if (nm_q[62:47] == 16'd0) begin
			nm_nx = nm_q << 16;
			ne_nx = ne_q - 12'sd16;
		end else if (nm_q[62:59] == 4'd0) begin
			nm_nx = nm_q << 4;
			ne_nx = ne_q - 12'sd4;
		end else if (!nm_q[62]) begin
			nm_nx = nm_q << 1;
			ne_nx = ne_q - 12'sd1;
		end
	end

	// Alignment of the smaller addend, with a sticky bit.
	logic        hi_prod;
	logic [63:0] mhi, mlo, lo_al, lo_sh;
	logic signed [11:0] ehi, elo;
	logic [11:0] dd;
	logic [5:0]  d6;
	always_comb begin
		hi_prod = (pe_q > xc_q) || ((pe_q == xc_q) && (pm_q >= mc_q));
		mhi = hi_prod ? pm_q : mc_q;
		mlo = hi_prod ? mc_q : pm_q;
		ehi = hi_prod ? pe_q : xc_q;
		elo = hi_prod ? xc_q : pe_q;
		dd  = 12'(ehi - elo);
		d6  = dd[5:0];
		lo_sh = mlo >> d6;
		if (dd >= 12'd63)
			lo_al = 64'd1;
		else
			lo_al = lo_sh | {63'd0, ((lo_sh << d6) != mlo)};
	end

	// Addition or subtraction of the aligned addends (pm_q holds the larger one).
	logic [63:0] sum_w;
	assign sum_w = (sp_q == sc_q) ? (pm_q + mc_q) : (pm_q - mc_q);

	// First rounding step: shift out the bits below the result's last place.
	logic signed [11:0] lim;
	logic        r_normal, r_uzero;
	logic [5:0]  sh6;
	logic [63:0] q_w, low_mask;
	logic        g_w, st_w;
	always_comb begin
		lim      = -12'sd149 - ne_q;
		r_normal = (lim <= 12'sd39);
		r_uzero  = !r_normal && (lim >= 12'sd64);
		sh6      = r_normal ? 6'd39 : lim[5:0];
		q_w      = nm_q >> sh6;
		g_w      = nm_q[sh6 - 6'd1];
		low_mask = (64'd1 << (sh6 - 6'd1)) - 64'd1;
		st_w     = (nm_q & low_mask) != 64'd0;
	end

	// Second rounding step: round to nearest even and pack.
	logic [24:0] q_rnd;
	logic [32:0] bits_w;
	logic [31:0] rnd_val;
	always_comb begin
		q_rnd  = q_q + {24'd0, g_q && (st_q || q_q[0])};
		bits_w = normal_q ? ({1'b0, expf_q, 23'd0} + {8'd0, q_rnd}) : {8'd0, q_rnd};
		if (uzero_q)
			rnd_val = {rsign_q, 31'd0};
		else if (bits_w >= {1'b0, INF_BITS})
			rnd_val = {rsign_q, 31'd0} | INF_BITS;
		else
			rnd_val = {rsign_q, bits_w[30:0]};
	end

	logic col_end, k_end, last_row;
	assign col_end  = ({1'b0, col_q} == neff - 5'd1);
	assign k_end    = ({2'b0, k_q} == keff - 10'd1);
	assign last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, rows_eff};

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= 4'd0;
			row_q   <= 16'd0;
			for (int i = 0; i < RESULT_CAP; i++)
				sums_q[i] <= 32'd0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (cmd == CMD_A) && ({2'b0, k_index} < keff)) begin
						col_q   <= 4'd0;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_UNPK;
				S_UNPK: state_q <= spec ? S_WB : S_NRMP;
				S_NRMP: begin
					if (nrm_done)
						state_q <= czero_q ? S_RND1 : S_NRMC;
				end
				S_NRMC: begin
					if (nrm_done)
						state_q <= S_ALGN;
				end
				S_ALGN: state_q <= S_ADD;
				S_ADD: state_q <= (sum_w == 64'd0) ? S_WB : S_NRMR;
				S_NRMR: begin
					if (nrm_done)
						state_q <= S_RND1;
				end
				S_RND1: state_q <= S_RND2;
				S_RND2: state_q <= S_WB;
				S_WB: begin
					sums_q[col_q] <= res_q;
					if (col_end) begin
						col_q   <= 4'd0;
						state_q <= k_end ? S_OUT : S_IDLE;
					end else begin
						col_q   <= col_q + 4'd1;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						if (col_end) begin
							row_q   <= last_row ? 16'd0 : row_q + 16'd1;
							col_q   <= 4'd0;
							state_q <= S_IDLE;
						end else
							col_q <= col_q + 4'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded under the sequencer's state.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			k_q <= k_index;
			a_q <= value;
		end
		unique case (state_q)
			S_UNPK: begin
				res_q   <= spec_val;
				nm_q    <= {16'd0, prod};
				ne_q    <= pe_w;
				mc_q    <= {40'd0, mcw};
				xc_q    <= xc_w;
				sp_q    <= sp_w;
				sc_q    <= c_op[31];
				czero_q <= c_zero;
				rsign_q <= sp_w;
			end
			S_NRMP: begin
				if (nrm_done) begin
					pm_q <= nm_q >> 1;
					pe_q <= ne_q + 12'sd1;
					if (!czero_q) begin
						nm_q <= mc_q;
						ne_q <= xc_q;
					end
				end else begin
					nm_q <= nm_nx;
					ne_q <= ne_nx;
				end
			end
			S_NRMC: begin
				if (nrm_done) begin
					mc_q <= nm_q >> 1;
					xc_q <= ne_q + 12'sd1;
				end else begin
					nm_q <= nm_nx;
					ne_q <= ne_nx;
				end
			end
			S_ALGN: begin
				pm_q <= mhi;
				mc_q <= lo_al;
				pe_q <= ehi;
				sp_q <= hi_prod ? sp_q : sc_q;
				sc_q <= hi_prod ? sc_q : sp_q;
			end
			S_ADD: begin
				res_q   <= 32'd0;
				nm_q    <= sum_w;
				ne_q    <= pe_q;
				rsign_q <= sp_q;
			end
			S_NRMR: begin
				if (!nrm_done) begin
					nm_q <= nm_nx;
					ne_q <= ne_nx;
				end
			end
			S_RND1: begin
				q_q      <= q_w[24:0];
				g_q      <= g_w;
				st_q     <= st_w;
				normal_q <= r_normal;
				uzero_q  <= r_uzero;
				expf_q   <= 9'(ne_q + 12'sd188);
			end
			S_RND2: res_q <= rnd_val;
			default: ;
		endcase
	end

	// Result transaction fields.
	assign out_row     = row_q;
	assign out_col     = col_q;
	assign out_value   = sums_q[col_q];
	assign row_last    = col_end;
	assign matrix_last = col_end && last_row;

endmodule
`default_nettype wire

[tb/sv/tb_f32_gemm_row_engine.sv]
// Self-checking testbench for the single precision GEMM row engine.
`timescale 1ns / 100ps
`default_nettype none
module tb_f32_gemm_row_engine;
	import f32gemm_pkg::*;

	localparam int MAXK = 256;
	localparam int MAXN = 16;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct packed {
		logic [15:0] row;
		logic [3:0]  col;
		logic [31:0] val;
		logic        rlast;
		logic        mlast;
	} c_elem_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = 1'b0;
	logic [7:0] k_index = '0;
	logic [3:0] col_index = '0;
	logic [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] out_row;
	logic [3:0] out_col;
	logic [31:0] out_value;
	logic row_last, matrix_last;

	// Predictor state and configuration.
	logic [31:0] b_store [MAXK*MAXN];
	logic [31:0] col_sum [MAXN];
	logic [15:0] row_ptr;
	logic [8:0]  cfg_k;
	logic [4:0]  cfg_n;
	logic [15:0] cfg_rows;

	c_elem_t expected_c [$];
	int  error_count = 0;
	int  idle_cycles = 0;
	bit  idling_on = 1'b1;

	f32_gemm_row_engine u_dut (.*);

	always #10 clk = ~clk;

	// ---------------- IEEE single FMA predictor ----------------
	function automatic int msb64(logic [63:0] v);
		int p;
		p = 63;
		while (p > 0 && !v[p]) p--;
		return p;
	endfunction

	function automatic bit is_nan(logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 0);
	endfunction

	function automatic logic [31:0] round_single(logic s, logic [63:0] m, int e);
		int p, sh, lim;
		bit normal;
		logic [63:0] q, rem, half, bits;
		p = msb64(m);
		sh = p - 23;
		lim = -149 - e;
		normal = (sh >= lim);
		if (!normal) sh = lim;
		if (sh >= 64) return {s, 31'd0};
		if (sh <= 0) begin
			q = m << (-sh);
		end else begin
			rem = m & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			q = m >> sh;
			if (rem > half || (rem == half && q[0])) q++;
		end
		if (normal) bits = (64'(p + e + 126) << 23) + q;
		else bits = q;
		if (bits >= 64'(INF_BITS)) return {s, 31'd0} | INF_BITS;
		return {s, bits[30:0]};
	endfunction

	function automatic logic [31:0] fused_mul_add(logic [31:0] a, logic [31:0] b,
			logic [31:0] c);
		logic sp, shi, slo;
		bit az, bz, cz;
		logic [63:0] pm, mc, mhi, mlo, lo, m;
		int pe, xc, ehi, elo, d, n;
		sp = a[31] ^ b[31];
		az = a[30:0] == 0;
		bz = b[30:0] == 0;
		cz = c[30:0] == 0;
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		if (is_nan(c)) return c | QUIET_BIT;
		if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
			if (az || bz) return DEFAULT_NAN;
			if (c[30:23] == 8'hFF && c[31] != sp) return DEFAULT_NAN;
			return {sp, 31'd0} | INF_BITS;
		end
		if (c[30:23] == 8'hFF) return c;
		if (az || bz) begin
			if (cz) return {sp & c[31], 31'd0};
			return c;
		end
		pm = 64'({a[30:23] != 0, a[22:0]}) * 64'({b[30:23] != 0, b[22:0]});
		pe = (((a[30:23] != 0) ? int'(a[30:23]) : 1) - 150)
			+ (((b[30:23] != 0) ? int'(b[30:23]) : 1) - 150);
		n = 61 - msb64(pm);
		pm = pm << n;
		pe -= n;
		if (cz) return round_single(sp, pm, pe);
		mc = 64'({c[30:23] != 0, c[22:0]});
		xc = ((c[30:23] != 0) ? int'(c[30:23]) : 1) - 150;
		n = 61 - msb64(mc);
		mc = mc << n;
		xc -= n;
		if (pe > xc || (pe == xc && pm >= mc)) begin
			mhi = pm; ehi = pe; shi = sp; mlo = mc; elo = xc; slo = c[31];
		end else begin
			mhi = mc; ehi = xc; shi = c[31]; mlo = pm; elo = pe; slo = sp;
		end
		d = ehi - elo;
		if (d >= 63) lo = 64'd1;
		else lo = (mlo >> d) | 64'((mlo & ((64'd1 << d) - 1)) != 0);
		if (shi == slo) begin
			m = mhi + lo;
		end else begin
			m = mhi - lo;
			if (m == 0) return 32'd0;
		end
		return round_single(shi, m, ehi);
	endfunction

	// Update the model for one accepted transaction and queue the row it completes.
	task automatic predict_gemm_row(logic c, logic [7:0] k, logic [3:0] col, logic [31:0] v);
		int kq, nq, rq;
		bit lastrow;
		c_elem_t e;
		if (c == CMD_B) begin
			b_store[k*MAXN + col] = v;
			return;
		end
		kq = (cfg_k < 1) ? 1 : ((cfg_k > MAXK) ? MAXK : cfg_k);
		nq = (cfg_n < 1) ? 1 : ((cfg_n > MAXN) ? MAXN : cfg_n);
		rq = (cfg_rows < 1) ? 1 : cfg_rows;
		if (k >= kq) return;
		for (int i = 0; i < nq; i++)
			col_sum[i] = fused_mul_add(v, b_store[k*MAXN + i], (k == 0) ? 32'd0 : col_sum[i]);
		if (k != kq - 1) return;
		lastrow = (32'(row_ptr) + 1) >= rq;
		for (int i = 0; i < nq; i++) begin
			e.row = row_ptr;
			e.col = 4'(i);
			e.val = col_sum[i];
			e.rlast = (i == nq - 1);
			e.mlast = (i == nq - 1) && lastrow;
			expected_c.push_back(e);
		end
		row_ptr = lastrow ? 16'd0 : row_ptr + 1;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	// Result checker and output-side stall generator.
	always @(posedge clk) begin
		c_elem_t e;
		if (out_valid && out_ready) begin
			if (expected_c.size() == 0) begin
				report_mismatch("unexpected result", out_value, 32'd0);
			end else begin
				e = expected_c.pop_front();
				if (out_row != e.row)
					report_mismatch("out_row", 32'(out_row), 32'(e.row));
				if (out_col != e.col)
					report_mismatch("out_col", 32'(out_col), 32'(e.col));
				if (out_value != e.val) report_mismatch("out_value", out_value, e.val);
				if (row_last != e.rlast)
					report_mismatch("row_last", 32'(row_last), 32'(e.rlast));
				if (matrix_last != e.mlast)
					report_mismatch("matrix_last", 32'(matrix_last), 32'(e.mlast));
			end
		end
	end

	int out_hold = 0;
	always @(posedge clk) begin
		if (!idling_on) begin
			out_ready <= 1'b1;
		end else if (out_hold > 0) begin
			out_hold <= out_hold - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			out_hold <= $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------
	// Valid stays high after acceptance; the next call either replaces the payload
	// or drops valid for an idle gap, and wait_drained drops it before anything else.
	task automatic send_item(logic c, logic [7:0] k, logic [3:0] col, logic [31:0] v);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd <= c;
		k_index <= k;
		col_index <= col;
		value <= v;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_gemm_row(c, k, col, v);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_c.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	// One write; the select lines stay up so the next write can follow directly.
	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 4'(idx) << 2;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_K_COUNT:   cfg_k = data[8:0];
			REG_N_COUNT:   cfg_n = data[4:0];
			REG_ROW_COUNT: cfg_rows = data[15:0];
			default: ;
		endcase
	endtask

	task automatic configure(int k, int n, int rows);
		wait_drained();
		write_reg(REG_K_COUNT, 32'(k));
		write_reg(REG_N_COUNT, 32'(n));
		write_reg(REG_ROW_COUNT, 32'(rows));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] rand_float();
		case ($urandom_range(0, 9))
			0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'h00, 23'($urandom)};
			1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom_range(0, 3))};
			2: return $urandom;
			3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'd0};
			default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0,
				8'($urandom_range(100, 154)), 23'($urandom)};
		endcase
	endfunction

	// Fill the whole active B region so no unwritten entry is ever read.
	task automatic load_b(int k, int n);
		for (int r = 0; r < k; r++)
			for (int c = 0; c < n; c++)
				send_item(CMD_B, 8'(r), 4'(c), rand_float());
	endtask

	task automatic send_row(int k);
		for (int r = 0; r < k; r++)
			send_item(CMD_A, 8'(r), 4'($urandom), rand_float());
	endtask

	// ---------------- tests ----------------
	task automatic test_special_values();
		logic [31:0] specials [10] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0001, 32'h7F80_0001, 32'h0000_0001, 32'h7F7F_FFFF, 32'h3F80_0000,
			32'hFFFF_FFFF};
		configure(1, 4, 3);
		send_item(CMD_B, 8'd0, 4'd0, 32'h7F80_0000);
		send_item(CMD_B, 8'd0, 4'd1, 32'h0);
		send_item(CMD_B, 8'd0, 4'd2, 32'h7FA0_0000);
		send_item(CMD_B, 8'd0, 4'd3, 32'h8000_0001);
		foreach (specials[i]) send_item(CMD_A, 8'd0, 4'd15, specials[i]);
		// Out of range A index is ignored; top-corner B write is legal.
		send_item(CMD_A, 8'd255, 4'd0, 32'h3F80_0000);
		send_item(CMD_B, 8'd255, 4'd15, 32'hFFFF_FFFF);
	endtask

	task automatic test_max_dims();
		configure(3, 16, 2);
		load_b(3, 16);
		send_row(3);
		send_row(3);
		// Sums restart at k zero, even when a row was left unfinished.
		send_item(CMD_A, 8'd0, 4'd0, 32'h3F80_0000);
		send_item(CMD_A, 8'd0, 4'd0, 32'h4000_0000);
		send_item(CMD_A, 8'd1, 4'd0, 32'h4040_0000);
		send_item(CMD_A, 8'd2, 4'd0, 32'h4080_0000);
	endtask

	// A K above the maximum saturates to it; A is sent only for k 0, 254 and 255.
	task automatic test_wide_k();
		configure(300, 1, 1);
		send_item(CMD_B, 8'd254, 4'd0, rand_float());
		send_item(CMD_B, 8'd255, 4'd0, rand_float());
		send_item(CMD_A, 8'd0, 4'd0, rand_float());
		send_item(CMD_A, 8'd254, 4'd0, rand_float());
		send_item(CMD_A, 8'd255, 4'd0, rand_float());
		configure(0, 31, 0);
		send_row(1);
	endtask

	task automatic test_random(int count);
		int k, n, sent;
		sent = 0;
		while (sent < count) begin
			k = $urandom_range(1, 6);
			n = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(1, 5);
			configure(k, n, $urandom_range(1, 4));
			load_b(k, n);
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 7) == 0)
					send_item(CMD_A, 8'($urandom), 4'($urandom), $urandom);
				if ($urandom_range(0, 9) == 0)
					send_item(CMD_B, 8'($urandom_range(0, k - 1)),
						4'($urandom_range(0, n - 1)), rand_float());
				send_row(k);
				sent += k;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < MAXK*MAXN; i++)
			b_store[i] = '0;
		for (int i = 0; i < MAXN; i++) col_sum[i] = '0;
		row_ptr = '0;
		cfg_k = 9'd1;
		cfg_n = 5'd1;
		cfg_rows = 16'd1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_values();
		test_max_dims();
		test_wide_k();
		test_random(28);
		idling_on = 1'b0;
		test_random(12);
		wait_drained();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
hw/rtl/f32gemm_pkg.sv
hw/rtl/f32_gemm_row_engine.sv
tb/sv/tb_f32_gemm_row_engine.sv
